>>> design/itfe_pkg.sv
// shared constants and types for the imu tilt feature extractor
// no dependencies
package itfe_pkg;

    localparam int DEG_FRAC = 16;
    localparam int ATAN_ENTRIES = 24;
    localparam int ZW = 28;

    localparam logic [2:0] REG_GAIN     = 3'd0;
    localparam logic [2:0] REG_NORM     = 3'd1;
    localparam logic [2:0] REG_FLAT_S   = 3'd2;
    localparam logic [2:0] REG_FLAT_U   = 3'd3;
    localparam logic [2:0] REG_VERT_S   = 3'd4;
    localparam logic [2:0] REG_VERT_U   = 3'd5;
    localparam logic [2:0] REG_INV      = 3'd6;

    typedef struct packed {
        logic [31:0] norm_window;
        logic [31:0] flat_side;
        logic [31:0] flat_up;
        logic [31:0] vert_side;
        logic [31:0] vert_up;
        logic [31:0] inv;
    } t_limits;

    // atan(2^-i) in degrees, 16 fraction bits
    function automatic logic [ZW-1:0] atan_lut(input logic [4:0] i);
        logic [ZW-1:0] v;
        case (i)
            5'd0: v = 28'd2949120;
            5'd1: v = 28'd1740967;
            5'd2: v = 28'd919879;
            5'd3: v = 28'd466945;
            5'd4: v = 28'd234379;
            5'd5: v = 28'd117304;
            5'd6: v = 28'd58666;
            5'd7: v = 28'd29335;
            5'd8: v = 28'd14668;
            5'd9: v = 28'd7334;
            5'd10: v = 28'd3667;
            5'd11: v = 28'd1833;
            5'd12: v = 28'd917;
            5'd13: v = 28'd458;
            5'd14: v = 28'd229;
            5'd15: v = 28'd115;
            5'd16: v = 28'd57;
            5'd17: v = 28'd29;
            5'd18: v = 28'd14;
            5'd19: v = 28'd7;
            5'd20: v = 28'd4;
            5'd21: v = 28'd2;
            5'd22: v = 28'd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

>>> design/itfe_sqrt.sv
// bit-pair restoring integer square root, one result bit per cycle
// depends on itfe_pkg
module itfe_sqrt
    import itfe_pkg::*;
#(
    parameter int IW = 34,
    parameter int OW = 17
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [IW-1:0] i_value,
    output logic          o_done,
    output logic [OW-1:0] o_root
);
    localparam int RW = 2 * OW;
    localparam int CW = $clog2(OW + 1);

    logic [RW-1:0] r_rem, n_rem;
    logic [RW-1:0] r_val, n_val;
    logic [OW-1:0] r_root, n_root;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_busy, n_busy;
    logic [OW+1:0] trial;
    logic [OW+1:0] part;

    always_comb begin
        n_rem = r_rem;
        n_val = r_val;
        n_root = r_root;
        n_cnt = r_cnt;
        n_busy = r_busy;
        part = {r_rem[OW-1:0], r_val[RW-1 -: 2]};
        trial = {r_root, 2'b01};
        if (i_start) begin
            n_val = RW'(i_value);
            n_rem = '0;
            n_root = '0;
            n_cnt = CW'(OW);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_val = {r_val[RW-3:0], 2'b00};
            if (part >= trial) begin
                n_rem = RW'(part - trial);
                n_root = {r_root[OW-2:0], 1'b1};
            end else begin
                n_rem = RW'(part);
                n_root = {r_root[OW-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt <= n_cnt;
        end
        r_rem <= n_rem;
        r_val <= n_val;
        r_root <= n_root;
    end

    assign o_done = r_busy && (r_cnt == CW'(1));
    assign o_root = n_root;
endmodule

>>> design/itfe_cordic.sv
// vectoring cordic, one micro-rotation per cycle, gives atan2 in degrees
// depends on itfe_pkg
module itfe_cordic
    import itfe_pkg::*;
#(
    parameter int SW = 16,
    parameter int AFB = 7,
    parameter int STEPS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [SW-1:0] i_ay,
    input  logic signed [SW-1:0] i_az,
    output logic                 o_done,
    output logic signed [15:0]   o_angle
);
    localparam int VW = SW + 14 + 3;
    localparam int NS = (STEPS < ATAN_ENTRIES) ? STEPS : ATAN_ENTRIES;
    localparam int ZWI = ZW + 2;
    localparam int SH = DEG_FRAC - AFB;
    localparam int LIM = 180 << AFB;

    logic signed [VW-1:0]  r_x, r_y, n_x, n_y;
    logic signed [ZWI-1:0] r_z, n_z;
    logic [4:0]            r_i, n_i;
    logic                  r_busy, n_busy;
    logic signed [VW-1:0]  xs, ys, x0, y0;
    logic signed [ZWI-1:0] base, zr, lim;
    logic signed [SW:0]    nay, aaz;

    always_comb begin
        nay = -((SW+1)'(i_ay));
        aaz = (SW+1)'(i_az);
        x0 = VW'(aaz);
        y0 = VW'(nay);
        base = '0;
        if (i_az < 0) begin
            base = (nay >= 0) ? ZWI'(180 <<< DEG_FRAC) : -ZWI'(180 <<< DEG_FRAC);
            x0 = -x0;
            y0 = -y0;
        end
        xs = r_x >>> r_i;
        ys = r_y >>> r_i;
        n_x = r_x;
        n_y = r_y;
        n_z = r_z;
        n_i = r_i;
        n_busy = r_busy;
        if (i_start) begin
            n_x = x0 <<< 14;
            n_y = y0 <<< 14;
            n_z = base;
            n_i = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (r_y >= 0) begin
                n_x = r_x + ys;
                n_y = r_y - xs;
                n_z = r_z + ZWI'(atan_lut(r_i));
            end else begin
                n_x = r_x - ys;
                n_y = r_y + xs;
                n_z = r_z - ZWI'(atan_lut(r_i));
            end
            n_i = r_i + 1'b1;
            if (r_i == 5'(NS - 1)) n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_i <= '0;
        end else begin
            r_busy <= n_busy;
            r_i <= n_i;
        end
        r_x <= n_x;
        r_y <= n_y;
        r_z <= n_z;
    end

    // rounding and clamp on the accumulated angle
    always_comb begin
        lim = ZWI'(LIM);
        zr = (r_z + ZWI'(1 <<< (SH - 1))) >>> SH;
        if (zr > lim) zr = lim;
        if (zr < -lim) zr = -lim;
        o_angle = 16'(zr);
    end

    assign o_done = r_busy ? 1'b0 : 1'b1;
endmodule

>>> design/imu_tilt_feature_extractor_core.sv
// imu tilt feature extractor top level
// uses itfe_pkg, itfe_sqrt and itfe_cordic
//
// usage:
//  input channel: i_valid / o_stall carry one imu sample word
//  (three accelerations in q4.12 g and one gyro rate)
//  output channel: o_valid / i_stall carry one feature word per sample
//  config port: i_cfg_we, i_cfg_index, i_cfg_data, written while idle
//  sequence: after acceptance the three squares go through one shared
//  multiplier, then the three filter products; the cordic (started after
//  the filter) outlasts the square root (17 iterations, started after the
//  squares); the run state then joins the two and the output state
//  registers the word
//  o_stall is low only in idle, so a new sample waits until the last one has left the output state
//  reset: filters unseeded, flags clear, config registers at defaults
//  a stalled result holds in the output register until taken; the next
//  sample can be accepted meanwhile and then waits in the output state
module imu_tilt_feature_extractor_core
    import itfe_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16,
    parameter int ACCEL_FRAC_BITS = 12,
    parameter int ANGLE_FRAC_BITS = 7,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [SAMPLE_WIDTH-1:0] i_accel_x,
    input  logic signed [SAMPLE_WIDTH-1:0] i_accel_y,
    input  logic signed [SAMPLE_WIDTH-1:0] i_accel_z,
    input  logic signed [SAMPLE_WIDTH-1:0] i_gyro_x,
    input  logic                          i_cfg_we,
    input  logic [2:0]                    i_cfg_index,
    input  logic [31:0]                   i_cfg_data,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [SAMPLE_WIDTH-1:0]        o_accel_norm,
    output logic signed [SAMPLE_WIDTH-1:0] o_filtered_x,
    output logic signed [SAMPLE_WIDTH-1:0] o_filtered_y,
    output logic signed [SAMPLE_WIDTH-1:0] o_filtered_z,
    output logic signed [15:0]            o_climb_angle,
    output logic [SAMPLE_WIDTH-1:0]        o_gyro_magnitude,
    output logic                          o_norm_ok,
    output logic                          o_is_flat,
    output logic                          o_is_vertical,
    output logic                          o_is_inverted
);
    localparam int SW = SAMPLE_WIDTH;
    localparam int PW = 2 * SW + 2;      // sum of three squares
    localparam int RW = SW + 1;          // root width
    localparam int DW = SW + 1;          // filter difference
    localparam int MW = DW + 18;         // gain product
    // near-zero threshold: |v|*10000 < 2^frac
    localparam int NZ = ((1 << ACCEL_FRAC_BITS) + 9999) / 10000;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_FLT  = 3'd2;
    localparam logic [2:0] ST_RUN  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0] r_state, n_state;
    logic [1:0] r_ph, n_ph;

    // configuration
    logic [16:0] r_gain;
    t_limits     r_lim;

    // sample and filter state
    logic signed [SW-1:0] r_ax, r_ay, r_az, r_gx;
    logic signed [SW-1:0] r_lpx, r_lpy, r_lpz;
    logic                 r_seeded, r_flat, r_vert, r_inv;
    logic [PW-1:0]        r_sq;

    // one shared signed multiplier, operands muxed by state and phase
    logic signed [DW:0]   mul_a;
    logic signed [17:0]   mul_b;
    logic signed [MW-1:0] mul_p;
    logic signed [SW-1:0] cur_in, cur_lp, new_lp;
    logic signed [DW-1:0] diff;

    logic       sq_start, sq_done, cd_start, cd_done;
    logic [RW-1:0] root;
    logic signed [15:0] angle;
    logic [RW-1:0] r_norm;
    logic       r_sq_fin;

    // outputs
    logic r_ovalid;
    logic [SW-1:0] r_onorm, r_ogyro;
    logic signed [SW-1:0] r_ofx, r_ofy, r_ofz;
    logic signed [15:0] r_oang;
    logic r_ook;

    always_comb begin
        case (r_ph)
            2'd0: begin cur_in = r_ax; cur_lp = r_lpx; end
            2'd1: begin cur_in = r_ay; cur_lp = r_lpy; end
            default: begin cur_in = r_az; cur_lp = r_lpz; end
        endcase
        diff = DW'(cur_in) - DW'(cur_lp);
        if (r_state == ST_MUL) begin
            mul_a = (DW+1)'(cur_in);
            mul_b = 18'(cur_in);
        end else begin
            mul_a = (DW+1)'(diff);
            mul_b = 18'({1'b0, r_gain});
        end
        mul_p = MW'(mul_a * mul_b);
        if (!r_seeded) new_lp = cur_in;
        else if (r_gain == 17'd0) new_lp = cur_lp;
        else if (r_gain[16]) new_lp = cur_in;
        else new_lp = SW'(cur_lp + SW'((mul_p + MW'(32768)) >>> 16));
    end

    // norm window and hysteresis on the new filtered values
    logic ok, f_n, v_n, i_n;
    logic [SW-1:0] ya, za;
    logic signed [15:0] lo_s, hi_s;
    always_comb begin
        ok = (r_norm >= RW'(r_lim.norm_window[15:0]))
          && (r_norm <= RW'(r_lim.norm_window[31:16]));
        ya = r_lpy[SW-1] ? SW'(-r_lpy) : SW'(r_lpy);
        za = r_lpz[SW-1] ? SW'(-r_lpz) : SW'(r_lpz);
        f_n = r_flat ?
            !(!ok || ({1'b0, ya} > (SW+1)'(r_lim.flat_side[31:16]))
              || (r_lpz < $signed(r_lim.flat_up[31:16]))) :
            (ok && ({1'b0, ya} <= (SW+1)'(r_lim.flat_side[15:0]))
              && (r_lpz >= $signed(r_lim.flat_up[15:0])));
        v_n = r_vert ?
            !(!ok || (r_lpy > $signed(r_lim.vert_side[31:16]))
              || ({1'b0, za} > (SW+1)'(r_lim.vert_up[31:16]))) :
            (ok && (r_lpy <= $signed(r_lim.vert_side[15:0]))
              && ({1'b0, za} <= (SW+1)'(r_lim.vert_up[15:0])));
        lo_s = r_lim.inv[15:0];
        hi_s = r_lim.inv[31:16];
        i_n = r_inv ? !(!ok || (r_lpz > hi_s)) : (ok && (r_lpz <= lo_s));
    end

    logic near_zero;
    assign near_zero = ({1'b0, ya} < (SW+1)'(NZ)) && ({1'b0, za} < (SW+1)'(NZ));

    assign sq_start = (r_state == ST_MUL) && (r_ph == 2'd2);
    assign cd_start = (r_state == ST_FLT) && (r_ph == 2'd2);

    itfe_sqrt #(.IW(PW), .OW(RW)) u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(sq_start),
        .i_value(r_sq + PW'($unsigned(mul_p))), .o_done(sq_done), .o_root(root)
    );

    // started in the z filter phase: lp_y is already updated, lp_z is new_lp
    itfe_cordic #(.SW(SW), .AFB(ANGLE_FRAC_BITS), .STEPS(CORDIC_STEPS)) u_cordic (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(cd_start),
        .i_ay(r_lpy), .i_az(new_lp),
        .o_done(cd_done), .o_angle(angle)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        n_ph = r_ph;
        case (r_state)
            ST_IDLE: if (i_valid) begin n_state = ST_MUL; n_ph = 2'd0; end
            ST_MUL: begin
                n_ph = r_ph + 1'b1;
                if (r_ph == 2'd2) begin n_state = ST_FLT; n_ph = 2'd0; end
            end
            ST_FLT: begin
                n_ph = r_ph + 1'b1;
                if (r_ph == 2'd2) begin n_state = ST_RUN; n_ph = 2'd0; end
            end
            ST_RUN: if (r_sq_fin && cd_done && r_ph == 2'd1) n_state = ST_OUT;
                    else if (r_sq_fin && cd_done) n_ph = 2'd1;
            ST_OUT: if (!r_ovalid || !i_stall) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ph <= '0;
            r_gain <= 17'd13107;
            r_lim <= {32'd308678042, 32'd53674598, 32'd201330074,
                      32'd4133942272, 32'd147654451, 32'd4147377562};
            r_seeded <= 1'b0;
            r_flat <= 1'b0;
            r_vert <= 1'b0;
            r_inv <= 1'b0;
            r_lpx <= '0;
            r_lpy <= '0;
            r_lpz <= '0;
            r_ovalid <= 1'b0;
            r_sq_fin <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ph <= n_ph;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_GAIN:   r_gain <= i_cfg_data[16:0];
                    REG_NORM:   r_lim.norm_window <= i_cfg_data;
                    REG_FLAT_S: r_lim.flat_side <= i_cfg_data;
                    REG_FLAT_U: r_lim.flat_up <= i_cfg_data;
                    REG_VERT_S: r_lim.vert_side <= i_cfg_data;
                    REG_VERT_U: r_lim.vert_up <= i_cfg_data;
                    REG_INV:    r_lim.inv <= i_cfg_data;
                    default: ;
                endcase
            end
            if (sq_start) r_sq_fin <= 1'b0;
            else if (sq_done) r_sq_fin <= 1'b1;
            if (r_state == ST_FLT) begin
                case (r_ph)
                    2'd0: r_lpx <= new_lp;
                    2'd1: r_lpy <= new_lp;
                    default: begin r_lpz <= new_lp; r_seeded <= 1'b1; end
                endcase
            end
            if (r_state == ST_OUT && (!r_ovalid || !i_stall)) begin
                r_ovalid <= 1'b1;
                r_flat <= f_n;
                r_vert <= v_n;
                r_inv <= i_n;
            end else if (o_valid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_valid) begin
            r_ax <= i_accel_x;
            r_ay <= i_accel_y;
            r_az <= i_accel_z;
            r_gx <= i_gyro_x;
            r_sq <= '0;
        end
        if (r_state == ST_MUL && r_ph != 2'd2) r_sq <= r_sq + PW'($unsigned(mul_p));
        if (sq_done) r_norm <= root;
        if (r_state == ST_OUT && (!r_ovalid || !i_stall)) begin
            r_onorm <= SW'(r_norm);
            r_ofx <= r_lpx;
            r_ofy <= r_lpy;
            r_ofz <= r_lpz;
            r_ogyro <= r_gx[SW-1] ? SW'(-r_gx) : SW'(r_gx);
            r_oang <= near_zero ? 16'sd0 : angle;
            r_ook <= ok;
        end
    end

    assign o_stall = (r_state != ST_IDLE);
    assign o_valid = r_ovalid;
    assign o_accel_norm = r_onorm;
    assign o_filtered_x = r_ofx;
    assign o_filtered_y = r_ofy;
    assign o_filtered_z = r_ofz;
    assign o_climb_angle = r_oang;
    assign o_gyro_magnitude = r_ogyro;
    assign o_norm_ok = r_ook;
    assign o_is_flat = r_flat;
    assign o_is_vertical = r_vert;
    assign o_is_inverted = r_inv;

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> o_stall) else $error("accept while busy");
    a_seed_after_filter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FLT && r_ph == 2'd2) |=> r_seeded) else $error("not seeded");
    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_climb_angle <= 16'sd23040 && o_climb_angle >= -16'sd23040))
        else $error("angle out of range");
`endif
endmodule
